// ===== sv/sfc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_pkg: shared types and constants
// Field widths, plane packing helpers and the front-to-back request struct.
// ---------------------------------------------------------------------------
package sfc_pkg;
    localparam int MAX_PLANES = 6;
    localparam int PLANE_COUNT_DEF = 6;
    localparam int FIELD_W = 48;
    localparam int PLANE_W = 64;
    localparam int IDX_W = 3;
    // squared sums: e up to 17 bits -> e^2 34 bits, sum of 3 -> 36 bits
    localparam int SQ_W = 36;
    localparam int RT_W = 18;
    // world center: c 17b * m 16b -> 33b, sum of 3 plus t<<13 -> 36 bits
    localparam int WC_W = 36;
    // radius rl (18b) * s (17b) -> 35 bits, unsigned
    localparam int RAD_W = 35;

    typedef struct packed {
        logic signed [WC_W-1:0] wx;
        logic signed [WC_W-1:0] wy;
        logic signed [WC_W-1:0] wz;
        logic [SQ_W-1:0]        r2;
        logic [SQ_W-1:0]        row2;
    } sfc_req_t;

    function automatic logic signed [15:0] lane16(input logic [63:0] v, input int l);
        return v[16*l +: 16];
    endfunction
endpackage

// ===== sv/sfc_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_front: geometry front end
// Two-stage pipeline: box center/extent, row lengths and world center.
// ---------------------------------------------------------------------------
module sfc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sfc_pkg::FIELD_W-1:0] row_x,
    input  logic [sfc_pkg::FIELD_W-1:0] row_y,
    input  logic [sfc_pkg::FIELD_W-1:0] row_z,
    input  logic [sfc_pkg::FIELD_W-1:0] trans,
    input  logic [sfc_pkg::FIELD_W-1:0] bmin,
    input  logic [sfc_pkg::FIELD_W-1:0] bmax,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sfc_pkg::sfc_req_t         out_req
);
    import sfc_pkg::*;

    // stage 1: products
    logic                    v1_reg;
    logic signed [32:0]      prod_reg [3][3];
    logic signed [33:0]      esq_reg [3];
    logic [33:0]             msq_reg [3][3];
    logic signed [15:0]      t_reg [3];
    logic                    adv1, adv2;
    logic                    v2_reg;
    sfc_req_t                req_reg, req_next;

    assign adv2 = !v2_reg || out_ready;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [16:0] c [3];
        logic signed [16:0] e [3];
        logic signed [15:0] m [3][3];
        if (adv1 && in_valid) begin
            for (int j = 0; j < 3; j++) begin
                c[j] = 17'(lane16(64'(bmax), j)) + 17'(lane16(64'(bmin), j));
                e[j] = 17'(lane16(64'(bmax), j)) - 17'(lane16(64'(bmin), j));
                m[0][j] = lane16(64'(row_x), j);
                m[1][j] = lane16(64'(row_y), j);
                m[2][j] = lane16(64'(row_z), j);
                t_reg[j] <= lane16(64'(trans), j);
                esq_reg[j] <= 34'(e[j] * e[j]);
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= 33'(c[i] * m[i][j]);
                    msq_reg[i][j] <= 34'($unsigned(32'(m[i][j] * m[i][j])));
                end
            end
        end
    end

    always_comb begin
        logic [SQ_W-1:0] l [3];
        logic signed [WC_W-1:0] w [3];
        for (int j = 0; j < 3; j++) begin
            w[j] = (WC_W'(t_reg[j]) <<< 13) + WC_W'(prod_reg[0][j])
                 + WC_W'(prod_reg[1][j]) + WC_W'(prod_reg[2][j]);
            l[j] = SQ_W'(msq_reg[j][0]) + SQ_W'(msq_reg[j][1]) + SQ_W'(msq_reg[j][2]);
        end
        req_next.wx = w[0];
        req_next.wy = w[1];
        req_next.wz = w[2];
        req_next.r2 = SQ_W'($unsigned(esq_reg[0])) + SQ_W'($unsigned(esq_reg[1]))
                    + SQ_W'($unsigned(esq_reg[2]));
        req_next.row2 = (l[0] >= l[1] && l[0] >= l[2]) ? l[0] :
                        (l[1] >= l[2]) ? l[1] : l[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) req_reg <= req_next;
    end

    assign out_valid = v2_reg;
    assign out_req = req_reg;
endmodule

// ===== sv/sfc_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_fifo: request queue
// Small flop queue that decouples front and back ends.
// ---------------------------------------------------------------------------
module sfc_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  sfc_pkg::sfc_req_t wr_req,
    output logic              rd_valid,
    input  logic              rd_ready,
    output sfc_pkg::sfc_req_t rd_req
);
    import sfc_pkg::*;

    sfc_req_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_req = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_req;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 3'd4)
        else $error("fifo count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 3'd0) |-> !rd_valid) else $error("read from empty fifo");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 3'd1) else $error("fifo count");
endmodule

// ===== sv/sfc_isqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_isqrt: pipelined integer square root
// Restoring square root, two result bits per stage, floor result.
// ---------------------------------------------------------------------------
module sfc_isqrt #(
    parameter int IN_W = 36,
    parameter int STG = 9
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   din,
    output logic [IN_W/2-1:0] root
);
    localparam int RW = IN_W / 2;
    localparam int BPS = RW / STG;

    logic [IN_W-1:0] rem_reg [STG];
    logic [RW-1:0]   res_reg [STG];

    for (genvar s = 0; s < STG; s++) begin : g_stg
        logic [IN_W-1:0] rem_in;
        logic [RW-1:0]   res_in;

        if (s == 0) begin : g_head
            assign rem_in = din;
            assign res_in = '0;
        end else begin : g_body
            assign rem_in = rem_reg[s-1];
            assign res_in = res_reg[s-1];
        end

        always_ff @(posedge aclk) begin
            logic [IN_W-1:0] r;
            logic [RW-1:0]   q;
            logic [IN_W+1:0] trial;
            r = rem_in;
            q = res_in;
            for (int b = 0; b < BPS; b++) begin
                trial = ((IN_W+2)'(q) << (RW - s*BPS - b)) | ((IN_W+2)'(1) << (2*(RW-1-s*BPS-b)));
                if ((IN_W+2)'(r) >= trial) begin
                    r = IN_W'((IN_W+2)'(r) - trial);
                    q[RW-1-s*BPS-b] = 1'b1;
                end
            end
            if (en) begin
                rem_reg[s] <= r;
                res_reg[s] <= q;
            end
        end
    end

    assign root = res_reg[STG-1];
endmodule

// ===== sv/sfc_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfc_back: sphere radius and plane tests
// Square roots, radius product, per-plane dot products and the verdict.
// ---------------------------------------------------------------------------
module sfc_back #(
    parameter int PLANE_COUNT = sfc_pkg::PLANE_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sfc_pkg::sfc_req_t         in_req,
    input  logic [sfc_pkg::PLANE_W-1:0] planes [PLANE_COUNT],
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_visible
);
    import sfc_pkg::*;

    localparam int SQ_STG = 9;
    localparam int LAT = SQ_STG + 4;  // sqrt, radius, dot, sum, compare

    logic               adv;
    logic [LAT-1:0]     v_reg;
    logic [RT_W-1:0]    rl, sc;
    logic signed [WC_W-1:0] w_reg [SQ_STG][3];
    logic [RAD_W-1:0]   rad_reg;
    logic signed [WC_W-1:0] w2_reg [3];
    logic signed [52:0] pp_reg [PLANE_COUNT][4];
    logic signed [RAD_W+15:0] lim_reg, lim2_reg;
    logic signed [54:0] dot_reg [PLANE_COUNT];
    logic               vis_reg;

    // whole pipe stalls together while the output is held
    assign adv = !v_reg[LAT-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[LAT-1];
    assign out_visible = vis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    sfc_isqrt #(.IN_W(SQ_W), .STG(SQ_STG)) u_rl (
        .aclk(aclk), .en(adv), .din(in_req.r2), .root(rl));
    sfc_isqrt #(.IN_W(SQ_W), .STG(SQ_STG)) u_sc (
        .aclk(aclk), .en(adv), .din(in_req.row2), .root(sc));

    // world center rides alongside the square roots
    always_ff @(posedge aclk) begin
        if (adv) begin
            w_reg[0][0] <= in_req.wx;
            w_reg[0][1] <= in_req.wy;
            w_reg[0][2] <= in_req.wz;
            for (int s = 1; s < SQ_STG; s++) w_reg[s] <= w_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg <= RAD_W'(rl * sc);
            w2_reg <= w_reg[SQ_STG-1];
            lim_reg <= -((RAD_W+16)'(rad_reg) <<< 14);
            lim2_reg <= lim_reg;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                for (int j = 0; j < 3; j++) begin
                    pp_reg[p][j] <= 53'(lane16(planes[p], j) * w2_reg[j]);
                end
                pp_reg[p][3] <= 53'(lane16(planes[p], 3)) <<< 27;
                dot_reg[p] <= 55'(pp_reg[p][0]) + 55'(pp_reg[p][1])
                            + 55'(pp_reg[p][2]) + 55'(pp_reg[p][3]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic v;
        if (adv) begin
            v = 1'b1;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (dot_reg[p] < 55'(lim2_reg)) v = 1'b0;
            end
            vis_reg <= v;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid && $stable(out_visible))
        else $error("result dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready == (!out_valid || out_ready)) else $error("pipe stall mismatch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_valid) |=> v_reg[0]) else $error("lost request");
endmodule

// ===== sv/sphere_frustum_cull.sv =====
`timescale 1ns / 1ps
// An accepted request passes 2 front stages, the queue and 13 back stages
// (nine of them square root) before m_valid rises. Throughput: one object
// per cycle while m_ready is high; the nine-stage square root pipes set the depth.
// Reset (aresetn, synchronous, low) clears all plane registers to zero and
// empties the pipeline and the queue.
// ---------------------------------------------------------------------------
// sphere_frustum_cull: bounding sphere vs. frustum planes
// Front end builds the world center and squared sizes, a queue decouples it
// from the back end that takes square roots and tests the planes.
// ---------------------------------------------------------------------------
module sphere_frustum_cull #(
    parameter int PLANE_COUNT = sfc_pkg::PLANE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic [sfc_pkg::IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data,
    // object requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [47:0] s_world_row_x,
    input  logic [47:0] s_world_row_y,
    input  logic [47:0] s_world_row_z,
    input  logic [47:0] s_translation,
    input  logic [47:0] s_box_min,
    input  logic [47:0] s_box_max,
    // verdicts
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_visible
);
    import sfc_pkg::*;

    typedef enum logic [2:0] {
        REG_NEAR = 3'd0, REG_FAR = 3'd1, REG_LEFT = 3'd2,
        REG_RIGHT = 3'd3, REG_TOP = 3'd4, REG_BOTTOM = 3'd5
    } reg_idx_t;

    logic [PLANE_W-1:0] plane_reg [MAX_PLANES];
    logic [PLANE_W-1:0] planes [PLANE_COUNT];

    // index 6 and 7 fall outside the list and are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PLANES; i++) plane_reg[i] <= '0;
        end else if (cfg_we && cfg_index <= 3'(REG_BOTTOM)) begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_pl
        assign planes[p] = plane_reg[p];
    end

    logic     f_valid, f_ready, b_valid, b_ready;
    sfc_req_t f_req, b_req;

    sfc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .row_x(s_world_row_x), .row_y(s_world_row_y), .row_z(s_world_row_z),
        .trans(s_translation), .bmin(s_box_min), .bmax(s_box_max),
        .out_valid(f_valid), .out_ready(f_ready), .out_req(f_req));

    sfc_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_req(f_req),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_req(b_req));

    sfc_back #(.PLANE_COUNT(PLANE_COUNT)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(b_valid), .in_ready(b_ready), .in_req(b_req),
        .planes(planes),
        .out_valid(m_valid), .out_ready(m_ready), .out_visible(m_visible));
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: sphere_frustum_cull testbench
// Drives object requests through the valid/ready channel, predicts each
// visibility verdict not typed in by exact integer math and checks every verdict
// in order. Plane registers are rewritten between phases while idle.
// ---------------------------------------------------------------------------
module tb_top;
    import sfc_pkg::*;

    localparam int N_RANDOM = 830;
    localparam int DRAIN_CYCLES = 40;

    // register indexes, in write-port order
    typedef enum logic [2:0] {
        PL_NEAR = 3'd0, PL_FAR = 3'd1, PL_LEFT = 3'd2,
        PL_RIGHT = 3'd3, PL_TOP = 3'd4, PL_BOTTOM = 3'd5,
        PL_BAD6 = 3'd6, PL_BAD7 = 3'd7
    } plane_idx_e;

    localparam logic VIS_UNKNOWN = 1'b0; // table marker: use predictor
    localparam logic VIS_KNOWN = 1'b1;

    typedef struct {
        logic [47:0] rx, ry, rz, tr, bmin, bmax;
    } object_t;

    typedef struct {
        object_t obj;
        logic    known;
        logic    vis;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [47:0] s_world_row_x, s_world_row_y, s_world_row_z;
    logic [47:0] s_translation, s_box_min, s_box_max;
    logic        m_valid;
    logic        m_ready;
    logic        m_visible;

    sphere_frustum_cull u_dut (.*);

    // shadow copy of the plane registers
    logic [63:0] planes [MAX_PLANES];
    logic        verdict_q [$];
    int          n_errors = 0;
    int          n_verdicts = 0;
    int          n_culled = 0;
    int          n_sent = 0;
    bit          quiet_sink = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard ceiling: ~850 requests, each at worst a long sink stall and a source gap
    initial begin
        #2000000;
        $display("sphere_frustum_cull verification failed");
        $finish;
    end

    function automatic longint lane(input logic [63:0] v, input int l);
        logic signed [15:0] f;
        f = v[16*l +: 16];
        return longint'(f);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // exact sphere-vs-planes verdict for one object
    function automatic logic predict_visible(input object_t o);
        longint m [3][3];
        longint c [3];
        longint w [3];
        longint unsigned r2, row2max, len2, rl, s;
        longint rad, lim, dot, lo, hi, e;
        logic [47:0] rows [3];
        logic vis;
        rows[0] = o.rx; rows[1] = o.ry; rows[2] = o.rz;
        r2 = 0; row2max = 0; vis = 1'b1;
        for (int i = 0; i < 3; i++) begin
            len2 = 0;
            for (int j = 0; j < 3; j++) begin
                m[i][j] = lane({16'h0, rows[i]}, j);
                len2 += longint'(m[i][j] * m[i][j]);
            end
            if (len2 > row2max) row2max = len2;
        end
        for (int j = 0; j < 3; j++) begin
            lo = lane({16'h0, o.bmin}, j);
            hi = lane({16'h0, o.bmax}, j);
            e = hi - lo;
            c[j] = hi + lo;
            r2 += e * e;
        end
        rl = int_sqrt(r2);
        s = int_sqrt(row2max);
        rad = longint'(rl * s);
        for (int j = 0; j < 3; j++) begin
            w[j] = lane({16'h0, o.tr}, j) * 8192;
            for (int i = 0; i < 3; i++) w[j] += c[i] * m[i][j];
        end
        lim = -(rad * 16384);
        for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
            dot = lane(planes[p], 3) * 134217728;
            for (int j = 0; j < 3; j++) dot += lane(planes[p], j) * w[j];
            if (dot < lim) vis = 1'b0;
        end
        return vis;
    endfunction

    task automatic write_plane(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx < MAX_PLANES) planes[idx] = val;
    endtask

    // block must be idle: nothing pending, then pipeline latency
    task automatic wait_idle();
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // one request; valid holds until accepted, random gap beforehand when gaps is set;
    // a typed-in verdict replaces the predicted one when known is set
    task automatic send_object(input object_t o, input bit gaps, input logic known,
                               input logic exp_vis);
        if (gaps)
            while ($urandom_range(99) < 31) @(negedge aclk);
        s_valid = 1'b1;
        s_world_row_x = o.rx; s_world_row_y = o.ry; s_world_row_z = o.rz;
        s_translation = o.tr; s_box_min = o.bmin; s_box_max = o.bmax;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        verdict_q.insert(verdict_q.size(), known ? exp_vis : predict_visible(o));
        n_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [15:0] rand_lane(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(16'h1000)) - 16'h0800;
            default: return 16'($urandom_range(16'h0400)) - 16'h0200;
        endcase
    endfunction

    function automatic logic [47:0] rand_triple(input int mode);
        return {rand_lane(mode), rand_lane(mode), rand_lane(mode)};
    endfunction

    function automatic object_t rand_object();
        object_t o;
        int mode;
        logic [15:0] lo, hi;
        mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
        o.rx = rand_triple($urandom_range(3) == 0 ? 0 : 1);
        o.ry = rand_triple($urandom_range(3) == 0 ? 0 : 1);
        o.rz = rand_triple($urandom_range(3) == 0 ? 0 : 1);
        o.tr = rand_triple(mode);
        // mostly well-formed boxes; some inverted
        for (int j = 0; j < 3; j++) begin
            lo = rand_lane(mode);
            hi = lo + 16'($urandom_range(255));
            if ($urandom_range(9) == 0) {lo, hi} = {hi, lo};
            o.bmin[16*j +: 16] = lo;
            o.bmax[16*j +: 16] = hi;
        end
        return o;
    endfunction

    function automatic logic [63:0] rand_plane();
        logic [15:0] nx, ny, nz;
        // unit-ish axis normal most of the time, raw bits otherwise
        if ($urandom_range(3) == 0) return {$urandom, $urandom};
        nx = '0; ny = '0; nz = '0;
        case ($urandom_range(2))
            0: nx = $urandom_range(1) ? 16'h4000 : 16'hC000;
            1: ny = $urandom_range(1) ? 16'h4000 : 16'hC000;
            default: nz = $urandom_range(1) ? 16'h4000 : 16'hC000;
        endcase
        return {rand_lane(1), nz, ny, nx};
    endfunction

    // sink: random back-pressure, except during a quiet stretch
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 31);
    end

    // verdict checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict with no request pending, actual %0b", $realtime,
                         m_visible);
                n_errors++;
            end else begin
                logic exp_vis;
                exp_vis = verdict_q.pop_front();
                if (m_visible !== exp_vis) begin
                    $display("%0t: visible mismatch expected %0b actual %0b", $realtime,
                             exp_vis, m_visible);
                    n_errors++;
                end
                n_verdicts++;
                if (!m_visible) n_culled++;
            end
        end
    end

    dir_row_t dir_tab [$];

    initial begin
        object_t o, z;
        dir_row_t r;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = PL_NEAR; cfg_data = '0;
        s_valid = 1'b0;
        s_world_row_x = '0; s_world_row_y = '0; s_world_row_z = '0;
        s_translation = '0; s_box_min = '0; s_box_max = '0;
        for (int p = 0; p < MAX_PLANES; p++) planes[p] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table; zero planes after reset mean always visible
        z = '{default: 48'h0};
        dir_tab.insert(dir_tab.size(), '{z, VIS_KNOWN, 1'b1});
        o = '{default: 48'hFFFF_FFFF_FFFF};
        dir_tab.insert(dir_tab.size(), '{o, VIS_KNOWN, 1'b1});
        o = '{rx: 48'h8000_8000_8000, ry: 48'h7FFF_7FFF_7FFF, rz: 48'h8000_7FFF_8000,
              tr: 48'h7FFF_8000_7FFF, bmin: 48'h8000_8000_8000, bmax: 48'h7FFF_7FFF_7FFF};
        dir_tab.insert(dir_tab.size(), '{o, VIS_KNOWN, 1'b1});
        o.bmin = 48'h7FFF_7FFF_7FFF; o.bmax = 48'h8000_8000_8000; // inverted box
        dir_tab.insert(dir_tab.size(), '{o, VIS_KNOWN, 1'b1});
        foreach (dir_tab[k])
            send_object(dir_tab[k].obj, 1'b0, dir_tab[k].known, dir_tab[k].vis);
        wait_idle();

        // plane extremes, out-of-range indexes ignored
        write_plane(PL_NEAR, 64'h0000_0000_0000_4000);      // x >= 0
        write_plane(PL_FAR, 64'h7FFF_0000_0000_C000);       // x <= 2047.9
        write_plane(PL_LEFT, 64'h8000_7FFF_7FFF_7FFF);      // unnormalized
        write_plane(PL_RIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_plane(PL_TOP, 64'h0000_4000_0000_0000);
        write_plane(PL_BOTTOM, 64'h0000_0000_4000_0000);
        write_plane(PL_BAD6, 64'hDEAD_BEEF_DEAD_BEEF);
        write_plane(PL_BAD7, 64'h8000_8000_8000_8000);
        dir_tab.delete();
        r.known = VIS_UNKNOWN; r.vis = 1'b0;
        r.obj = '{rx: 48'h0000_0000_1000, ry: 48'h0000_1000_0000, rz: 48'h1000_0000_0000,
                  tr: 48'h0100_0100_0100, bmin: 48'hFFF0_FFF0_FFF0, bmax: 48'h0010_0010_0010};
        for (int k = 0; k < 8; k++) begin
            dir_tab.insert(dir_tab.size(), r);
            r.obj.tr = {16'($urandom), 16'($urandom), 16'hFF00 + 16'(k * 40)};
        end
        foreach (dir_tab[k])
            send_object(dir_tab[k].obj, 1'b1, dir_tab[k].known, dir_tab[k].vis);
        wait_idle();

        // random phases with fresh plane sets between them
        for (int ph = 0; ph < 5; ph++) begin
            for (int p = 0; p < MAX_PLANES; p++) write_plane(3'(p), rand_plane());
            quiet_sink = (ph == 2);
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                send_object(rand_object(), ph != 2, VIS_UNKNOWN, 1'b0);
                // after request 40 of each phase the source holds off until every verdict is back
                if (k == 40) while (verdict_q.size() != 0) @(negedge aclk);
            end
            wait_idle();
            quiet_sink = 1'b0;
        end

        $display("%0d requests sent, %0d verdicts checked, %0d culled, over 7 plane sets",
                 n_sent, n_verdicts, n_culled);
        if (n_errors == 0 && verdict_q.size() == 0) begin
            $display("sphere_frustum_cull verification clean");
        end else begin
            $display("%0t: %0d mismatches, %0d verdicts missing", $realtime, n_errors,
                     verdict_q.size());
            $display("sphere_frustum_cull verification failed");
        end
        $finish;
    end
endmodule
